/* hdl/lidar_range_isolated_point_filter_unit_defines.svh */
// Assertion macros shared by the isolated point filter modules.
`ifndef LIDAR_RANGE_ISOLATED_POINT_FILTER_UNIT_DEFINES_SVH
`define LIDAR_RANGE_ISOLATED_POINT_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LRIP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LRIP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/lrip_pkg.sv */
// Types, constants and helper functions of the isolated point filter.
`timescale 1ns / 1ps
package lrip_pkg;

    localparam int RANGE_W = 16;
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_TOL = 8'd4;

    // Register values after reset.
    localparam logic [RANGE_W-1:0] RST_RANGE_MIN = 16'd100;
    localparam logic [RANGE_W-1:0] RST_RANGE_MAX = 16'd30000;
    localparam logic [RANGE_W-1:0] RST_NEAR_LIMIT = 16'd500;
    localparam logic [RANGE_W-1:0] RST_FAR_LIMIT = 16'd6000;
    localparam logic [RANGE_W-1:0] RST_NEIGHBOR_TOL = 16'd200;

    localparam logic [RANGE_W-1:0] RANGE_ALL_ONES = '1;

    typedef struct packed {
        logic [RANGE_W-1:0] range_min_mm;
        logic [RANGE_W-1:0] range_max_mm;
        logic [RANGE_W-1:0] near_limit_mm;
        logic [RANGE_W-1:0] far_limit_mm;
        logic [RANGE_W-1:0] neighbor_tolerance_mm;
    } cfg_t;

    // One sample ready for the back end, with all flags that do not
    // depend on the filtered left neighbor already worked out.
    typedef struct packed {
        logic [RANGE_W-1:0] range;
        logic               nan;
        logic               last;
        logic               keep_out;
        logic               cut;
        logic               right_valid;
        logic               right_far;
    } job_t;

    // Up to two jobs per accepted sample, in order; second implies first.
    typedef struct packed {
        logic first_valid;
        logic second_valid;
        job_t first;
        job_t second;
    } push_t;

    function automatic logic [RANGE_W-1:0] abs_diff(input logic [RANGE_W-1:0] a,
                                                    input logic [RANGE_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    // Strictly inside the open sensor window.
    function automatic logic in_window(input logic [RANGE_W-1:0] r, input cfg_t cfg);
        in_window = (r > cfg.range_min_mm) && (r < cfg.range_max_mm);
    endfunction

    // Classify everything that does not need the left neighbor.
    function automatic job_t make_job(input logic [RANGE_W-1:0] r,
                                      input logic               nan,
                                      input logic               right_present,
                                      input logic [RANGE_W-1:0] rr,
                                      input logic               rnan,
                                      input logic               last,
                                      input cfg_t               cfg);
        job_t j;
        j.range       = r;
        j.nan         = nan;
        j.last        = last;
        j.keep_out    = !nan && ((r > cfg.range_max_mm) || (r < cfg.range_min_mm));
        j.cut         = !nan && ((r < cfg.near_limit_mm) || (r > cfg.far_limit_mm));
        j.right_valid = right_present && !rnan && in_window(rr, cfg);
        j.right_far   = !right_present ||
                        (!rnan && !nan && (abs_diff(rr, r) > cfg.neighbor_tolerance_mm));
        make_job = j;
    endfunction

endpackage

/* hdl/lrip_channels.sv */
// Handshake interfaces of the sample, result and configuration channels.
`timescale 1ns / 1ps

interface lrip_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample_range;
    logic        sample_nan;
    logic        end_of_scan;
    modport source (output valid, sample_range, sample_nan, end_of_scan, input ready);
    modport sink (input valid, sample_range, sample_nan, end_of_scan, output ready);
endinterface

interface lrip_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] filtered_range;
    logic        filtered_nan;
    logic        removed;
    logic        last_of_scan;
    modport source (output valid, filtered_range, filtered_nan, removed, last_of_scan,
                    input ready);
    modport sink (input valid, filtered_range, filtered_nan, removed, last_of_scan,
                  output ready);
endinterface

interface lrip_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hdl/lrip_front.sv */
// Front end: holds each sample but the last of a scan until its right neighbor arrives, and classifies it.
`timescale 1ns / 1ps
module lrip_front
    import lrip_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                room,
    lrip_sample_if.sink         samples,
    output push_t               push
);

    logic [RANGE_W-1:0] pending_range_reg;
    logic [RANGE_W-1:0] pending_range_next;
    logic               pending_nan_reg;
    logic               pending_nan_next;
    logic               pending_present_reg;
    logic               pending_present_next;
    logic               accept;
    job_t               job_pending;
    job_t               job_last;

    assign samples.ready = room;
    assign accept = samples.valid && room;

    // Pending sample sees the incoming raw sample as its right neighbor;
    // a final sample has no right neighbor.
    always_comb
    begin
        job_pending = make_job(pending_range_reg, pending_nan_reg, 1'b1,
                               samples.sample_range, samples.sample_nan, 1'b0, cfg);
        job_last = make_job(samples.sample_range, samples.sample_nan, 1'b0,
                            '0, 1'b0, 1'b1, cfg);
    end

    // Order the jobs so that the second slot is used only with the first.
    always_comb
    begin
        push.first_valid  = 1'b0;
        push.second_valid = 1'b0;
        push.first        = job_pending;
        push.second       = job_last;
        if (accept)
        begin
            if (pending_present_reg)
            begin
                push.first_valid  = 1'b1;
                push.second_valid = samples.end_of_scan;
            end
            else
            begin
                push.first_valid = samples.end_of_scan;
                push.first       = job_last;
            end
        end
    end

    // Pending sample update; the end of a scan leaves nothing pending.
    always_comb
    begin
        pending_range_next   = pending_range_reg;
        pending_nan_next     = pending_nan_reg;
        pending_present_next = pending_present_reg;
        if (accept)
        begin
            pending_range_next   = samples.sample_range;
            pending_nan_next     = samples.sample_nan;
            pending_present_next = !samples.end_of_scan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_present_reg <= 1'b0;
        end
        else
        begin
            pending_present_reg <= pending_present_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pending_range_reg <= pending_range_next;
        pending_nan_reg   <= pending_nan_next;
    end

endmodule

/* hdl/lrip_queue.sv */
// Job queue between front and back end: up to two writes and one read per cycle.
`timescale 1ns / 1ps
`include "lidar_range_isolated_point_filter_unit_defines.svh"
module lrip_queue
    import lrip_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    input  logic  pop,
    output logic  room,
    output logic  head_valid,
    output job_t  head
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic [PTR_W-1:0] wr_ptr_plus2;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] push_cnt;

    // Room for the two jobs that one sample may produce.
    assign room       = count_reg <= CNT_W'(DEPTH - 2);
    assign head_valid = count_reg != '0;
    assign head       = slot_reg[rd_ptr_reg];

    // Pointer arithmetic with wrap at the queue depth.
    always_comb
    begin
        wr_ptr_plus1 = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        wr_ptr_plus2 = (wr_ptr_plus1 == PTR_LAST) ? '0 : wr_ptr_plus1 + 1'b1;
        push_cnt     = CNT_W'(push.first_valid) + CNT_W'(push.second_valid);
        wr_ptr_next  = wr_ptr_reg;
        if (push.second_valid)
        begin
            wr_ptr_next = wr_ptr_plus2;
        end
        else if (push.first_valid)
        begin
            wr_ptr_next = wr_ptr_plus1;
        end
        rd_ptr_next = rd_ptr_reg;
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + push_cnt - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push.first_valid)
        begin
            slot_reg[wr_ptr_reg] <= push.first;
        end
        if (push.second_valid)
        begin
            slot_reg[wr_ptr_plus1] <= push.second;
        end
    end

    `LRIP_ASSERT_IMP(a_pop_not_empty, clk, rst_n, pop, count_reg != '0, "pop from empty queue")
    `LRIP_ASSERT_IMP(a_push_has_room, clk, rst_n, push.first_valid, room, "push without room")
    `LRIP_ASSERT_IMP(a_push_order, clk, rst_n, push.second_valid, push.first_valid, "second job without first")
    `LRIP_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH), "queue overfilled")

endmodule

/* hdl/lrip_back.sv */
// Back end: applies the filtered left neighbor and registers each result.
`timescale 1ns / 1ps
`include "lidar_range_isolated_point_filter_unit_defines.svh"
module lrip_back
    import lrip_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          job_valid,
    input  job_t          job,
    output logic          pop,
    lrip_result_if.source results
);

    logic [RANGE_W-1:0] left_range_reg;
    logic               left_nan_reg;
    logic               left_present_reg;
    logic               left_present_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [RANGE_W-1:0] out_range_reg;
    logic               out_nan_reg;
    logic               out_removed_reg;
    logic               out_last_reg;
    logic               left_valid;
    logic               left_far;
    logic               rem;
    logic [RANGE_W-1:0] repl;
    logic [RANGE_W-1:0] res_range;
    logic               res_nan;

    assign pop = job_valid && (!out_valid_reg || results.ready);

    // Final classification against the filtered left neighbor.
    always_comb
    begin
        left_valid = left_present_reg && !left_nan_reg && in_window(left_range_reg, cfg);
        left_far   = !left_present_reg ||
                     (!left_nan_reg && !job.nan &&
                      (abs_diff(left_range_reg, job.range) > cfg.neighbor_tolerance_mm));
        rem        = !job.keep_out &&
                     (job.cut || (!left_valid && !job.right_valid) ||
                      (left_far && job.right_far));
        repl       = (cfg.range_max_mm == RANGE_ALL_ONES) ? RANGE_ALL_ONES
                                                          : cfg.range_max_mm + 1'b1;
        res_nan    = !rem && job.nan;
        if (rem)
        begin
            res_range = repl;
        end
        else if (job.nan)
        begin
            res_range = '0;
        end
        else
        begin
            res_range = job.range;
        end
    end

    // Control: result valid and left neighbor presence.
    always_comb
    begin
        out_valid_next    = out_valid_reg;
        left_present_next = left_present_reg;
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            out_valid_next    = 1'b1;
            left_present_next = !job.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            left_present_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg    <= out_valid_next;
            left_present_reg <= left_present_next;
        end
    end

    // Payload: output register and filtered left neighbor.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_range_reg   <= res_range;
            out_nan_reg     <= res_nan;
            out_removed_reg <= rem;
            out_last_reg    <= job.last;
            left_range_reg  <= res_range;
            left_nan_reg    <= res_nan;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.filtered_range = out_range_reg;
    assign results.filtered_nan   = out_nan_reg;
    assign results.removed        = out_removed_reg;
    assign results.last_of_scan   = out_last_reg;

    `LRIP_ASSERT_IMP(a_removed_not_nan, clk, rst_n, out_valid_reg && out_removed_reg, !out_nan_reg, "removed result flagged NaN")
    `LRIP_ASSERT_NXT(a_scan_end_clears, clk, rst_n, pop && job.last, !left_present_reg, "left neighbor kept across scans")
    `LRIP_ASSERT_NXT(a_pop_loads, clk, rst_n, pop, out_valid_reg, "transfer into result register lost")

endmodule

/* hdl/lidar_range_isolated_point_filter_unit.sv */
// Top level of the lidar range isolated point filter.
//
//  channel   direction  payload                                          accept
//  samples   in         sample_range, sample_nan, end_of_scan            valid & ready
//  results   out        filtered_range, filtered_nan, removed, last      valid & ready
//  cfg       in         index (8), data (16)                             valid & ready
//
// A sample other than the last of a scan is held until the next sample arrives, then
// passes through the job queue and then the result register.
// One sample per cycle is taken while the job queue has room; an end-of-scan transfer can
// push two jobs; the single result register drains one result per cycle when ready is high.
// Reset clears the pending sample, the left neighbor, the queue and the result valid.
// The input stalls only while the job queue lacks room for two jobs.
`timescale 1ns / 1ps
module lidar_range_isolated_point_filter_unit
    import lrip_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    lrip_sample_if.sink   samples,
    lrip_result_if.source results,
    lrip_cfg_if.sink      cfg
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    push_t push;
    logic  room;
    logic  head_valid;
    job_t  head;
    logic  pop;

    // Configuration registers; writes are always taken.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_RANGE_MIN:    cfg_next.range_min_mm          = cfg.data;
                REG_RANGE_MAX:    cfg_next.range_max_mm          = cfg.data;
                REG_NEAR_LIMIT:   cfg_next.near_limit_mm         = cfg.data;
                REG_FAR_LIMIT:    cfg_next.far_limit_mm          = cfg.data;
                REG_NEIGHBOR_TOL: cfg_next.neighbor_tolerance_mm = cfg.data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_min_mm          <= RST_RANGE_MIN;
            cfg_reg.range_max_mm          <= RST_RANGE_MAX;
            cfg_reg.near_limit_mm         <= RST_NEAR_LIMIT;
            cfg_reg.far_limit_mm          <= RST_FAR_LIMIT;
            cfg_reg.neighbor_tolerance_mm <= RST_NEIGHBOR_TOL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end, job queue and back end.
    lrip_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .room    (room),
        .samples (samples),
        .push    (push)
    );

    lrip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .room       (room),
        .head_valid (head_valid),
        .head       (head)
    );

    lrip_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (head_valid),
        .job       (head),
        .pop       (pop),
        .results   (results)
    );

endmodule

/* tb/sv/lrip_filter_checker.sv */
// Checker that predicts the filtered samples and compares them with the result channel.
`timescale 1ns / 1ps
module lrip_filter_checker
    import lrip_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    lrip_sample_if samples,
    lrip_result_if results,
    lrip_cfg_if    cfg,
    output int     fail_count,
    output int     expected_count
);

    // One filtered sample as the result channel carries it.
    typedef struct {
        logic [RANGE_W-1:0] range;
        logic               nan;
        logic               removed;
        logic               last;
    } filtered_t;

    filtered_t filtered_q[$];
    filtered_t oldest;
    cfg_t      regs;

    // Sample held back until its right neighbor arrives.
    logic [RANGE_W-1:0] held_range;
    logic               held_nan;
    logic               held_present;

    // Filtered left neighbor; cleared at the start of each scan.
    logic [RANGE_W-1:0] prev_range;
    logic               prev_nan;
    logic               prev_present;

    int mismatches = 0;
    int waiting = 0;

    assign fail_count = mismatches;
    assign expected_count = waiting;

    // A neighbor is usable when present, a number and strictly inside the window.
    function automatic logic beam_valid(input logic present, input logic [RANGE_W-1:0] v,
                                        input logic n);
        beam_valid = present && !n && (v > regs.range_min_mm) && (v < regs.range_max_mm);
    endfunction

    // A missing neighbor is far; a NaN on either side never is.
    function automatic logic beam_far(input logic present, input logic [RANGE_W-1:0] v,
                                      input logic n, input logic [RANGE_W-1:0] r,
                                      input logic rn);
        logic [RANGE_W-1:0] gap;
        gap = (v > r) ? (v - r) : (r - v);
        if (!present)
            beam_far = 1'b1;
        else if (n || rn)
            beam_far = 1'b0;
        else
            beam_far = gap > regs.neighbor_tolerance_mm;
    endfunction

    // Classify one sample against its neighbors and queue the filtered value.
    task automatic classify_sample(input logic [RANGE_W-1:0] r, input logic n,
                                   input logic rp, input logic [RANGE_W-1:0] rr,
                                   input logic rn, input logic last);
        logic      drop;
        filtered_t item;
        drop = 1'b0;
        if (!n && ((r > regs.range_max_mm) || (r < regs.range_min_mm)))
            drop = 1'b0;
        else if (!n && ((r < regs.near_limit_mm) || (r > regs.far_limit_mm)))
            drop = 1'b1;
        else if (!beam_valid(prev_present, prev_range, prev_nan) && !beam_valid(rp, rr, rn))
            drop = 1'b1;
        else if (beam_far(prev_present, prev_range, prev_nan, r, n) &&
                 beam_far(rp, rr, rn, r, n))
            drop = 1'b1;
        item.range = r;
        item.nan = n;
        item.removed = drop;
        item.last = last;
        if (drop)
        begin
            item.range = (regs.range_max_mm == RANGE_ALL_ONES) ? RANGE_ALL_ONES
                                                                : regs.range_max_mm + 1'b1;
            item.nan = 1'b0;
        end
        if (item.nan)
            item.range = '0;
        filtered_q.push_back(item);
        prev_range = item.range;
        prev_nan = item.nan;
        prev_present = 1'b1;
    endtask

    // Advance the scan state by one accepted sample.
    task automatic take_sample(input logic [RANGE_W-1:0] r, input logic n, input logic eos);
        if (held_present)
            classify_sample(held_range, held_nan, 1'b1, r, n, 1'b0);
        if (eos)
        begin
            classify_sample(r, n, 1'b0, '0, 1'b0, 1'b1);
            prev_present = 1'b0;
            prev_range = '0;
            prev_nan = 1'b0;
            held_present = 1'b0;
            held_range = '0;
            held_nan = 1'b0;
        end
        else
        begin
            held_range = r;
            held_nan = n;
            held_present = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Results are compared before new expectations are queued in the same cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.range_min_mm = RST_RANGE_MIN;
            regs.range_max_mm = RST_RANGE_MAX;
            regs.near_limit_mm = RST_NEAR_LIMIT;
            regs.far_limit_mm = RST_FAR_LIMIT;
            regs.neighbor_tolerance_mm = RST_NEIGHBOR_TOL;
            held_range = '0;
            held_nan = 1'b0;
            held_present = 1'b0;
            prev_range = '0;
            prev_nan = 1'b0;
            prev_present = 1'b0;
            filtered_q.delete();
            waiting <= 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (filtered_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no result, actual range=%0d nan=%0b rem=%0b last=%0b",
                             $time, results.filtered_range, results.filtered_nan,
                             results.removed, results.last_of_scan);
                end
                else
                begin
                    oldest = filtered_q.pop_front();
                    check_field("filtered_range", 32'(oldest.range),
                                32'(results.filtered_range));
                    check_field("filtered_nan", 32'(oldest.nan), 32'(results.filtered_nan));
                    check_field("removed", 32'(oldest.removed), 32'(results.removed));
                    check_field("last_of_scan", 32'(oldest.last), 32'(results.last_of_scan));
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_RANGE_MIN:    regs.range_min_mm = cfg.data;
                    REG_RANGE_MAX:    regs.range_max_mm = cfg.data;
                    REG_NEAR_LIMIT:   regs.near_limit_mm = cfg.data;
                    REG_FAR_LIMIT:    regs.far_limit_mm = cfg.data;
                    REG_NEIGHBOR_TOL: regs.neighbor_tolerance_mm = cfg.data;
                    default: ;
                endcase
            end
            if (samples.valid && samples.ready)
                take_sample(samples.sample_range, samples.sample_nan, samples.end_of_scan);
            waiting <= filtered_q.size();
        end
    end

endmodule

/* tb/sv/tb_lidar_range_isolated_point_filter_unit.sv */
// Testbench top: clock, reset, sample and register stimulus, and the final verdict.
`timescale 1ns / 1ps
module tb_lidar_range_isolated_point_filter_unit
    import lrip_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 100;
    localparam int SETTLE_CYCLES = 8;

    // Indexes past the last register; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX = 8'hFF;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   expected_count;
    int   cycle_count;

    // Stimulus controls; idle_on and hold_asked reach the receiver through
    // nonblocking assignments, steady_feed is read only by the stimulus process.
    logic idle_on;
    int   hold_asked;
    logic steady_feed;

    // Receiver state.
    int hold_served = 0;
    int hold_left = 0;
    int stall_left = 0;

    // Register values as last written, used only to aim the samples.
    int win_min;
    int win_max;
    int win_near;
    int win_far;
    int win_tol;

    lrip_sample_if samples_if();
    lrip_result_if results_if();
    lrip_cfg_if    cfg_if();

    lidar_range_isolated_point_filter_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    lrip_filter_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .samples        (samples_if),
        .results        (results_if),
        .cfg            (cfg_if),
        .fail_count     (fail_count),
        .expected_count (expected_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Result receiver: random stall bursts, plus one long hold on request.
    initial
    begin
        results_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                results_if.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                results_if.ready <= 1'b0;
            end
            else if (hold_served != hold_asked)
            begin
                hold_served = hold_asked;
                hold_left = LONG_HOLD - 1;
                results_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                results_if.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 11);
                results_if.ready <= 1'b0;
            end
            else
                results_if.ready <= 1'b1;
        end
    end

    // Offer one sample and wait for its transfer; valid stays high unless a gap follows.
    task automatic send_sample(input logic [RANGE_W-1:0] r, input logic n, input logic eos);
        samples_if.valid <= 1'b1;
        samples_if.sample_range <= r;
        samples_if.sample_nan <= n;
        samples_if.end_of_scan <= eos;
        do @(posedge clk); while (!samples_if.ready);
        if (idle_on && !steady_feed && $urandom_range(0, 5) == 0)
        begin
            samples_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Wait until every expected result has arrived, then let the pipeline settle.
    task automatic drain_results();
        samples_if.valid <= 1'b0;
        do @(posedge clk); while (expected_count != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register transfer; valid is left high for back-to-back writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value[RANGE_W-1:0];
        do @(posedge clk); while (!cfg_if.ready);
        case (idx)
            REG_RANGE_MIN:    win_min = value;
            REG_RANGE_MAX:    win_max = value;
            REG_NEAR_LIMIT:   win_near = value;
            REG_FAR_LIMIT:    win_far = value;
            REG_NEIGHBOR_TOL: win_tol = value;
            default: ;
        endcase
    endtask

    task automatic load_config(input int lo, input int hi, input int near_mm,
                               input int far_mm, input int tol);
        write_reg(REG_RANGE_MIN, lo);
        write_reg(REG_RANGE_MAX, hi);
        write_reg(REG_NEAR_LIMIT, near_mm);
        write_reg(REG_FAR_LIMIT, far_mm);
        write_reg(REG_NEIGHBOR_TOL, tol);
        cfg_if.valid <= 1'b0;
    endtask

    // Next range of a scan: mostly a walk around the previous one, with
    // boundary values, outliers and fully random values mixed in.
    function automatic int pick_range(input int prev);
        int v;
        case ($urandom_range(0, 19))
            0, 1: v = $urandom_range(0, 65535);
            2: v = win_min + int'($urandom_range(0, 2)) - 1;
            3: v = win_max + int'($urandom_range(0, 2)) - 1;
            4: v = win_near + int'($urandom_range(0, 2)) - 1;
            5: v = win_far + int'($urandom_range(0, 2)) - 1;
            6:
            begin
                if ($urandom_range(0, 1))
                    v = prev + win_tol + 1 + int'($urandom_range(0, 3000));
                else
                    v = prev - win_tol - 1 - int'($urandom_range(0, 3000));
            end
            7:
            begin
                if ($urandom_range(0, 1))
                    v = prev + win_tol + int'($urandom_range(0, 1));
                else
                    v = prev - win_tol - int'($urandom_range(0, 1));
            end
            default: v = prev - win_tol + int'($urandom_range(0, 2 * win_tol));
        endcase
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        pick_range = v;
    endfunction

    // One scan ending in end_of_scan; a noisy scan carries random fields throughout.
    task automatic run_scan(input int len, input logic noisy);
        int prev;
        int lo;
        int hi;
        logic n;
        lo = win_min + 1;
        hi = win_max - 1;
        if ($urandom_range(0, 1))
        begin
            if (win_near > lo)
                lo = win_near;
            if (win_far < hi)
                hi = win_far;
        end
        prev = (lo <= hi) ? int'($urandom_range(lo, hi)) : int'($urandom_range(0, 65535));
        for (int i = 0; i < len; i++)
        begin
            if (noisy)
            begin
                prev = $urandom_range(0, 65535);
                n = 1'($urandom_range(0, 1));
            end
            else
            begin
                prev = pick_range(prev);
                n = ($urandom_range(0, 11) == 0);
            end
            send_sample(prev[RANGE_W-1:0], n, i == len - 1);
        end
    endtask

    // Scans of mostly short lengths, about one in five of them noisy.
    task automatic run_phase(input int count);
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                len = 1;
            else if (pick < 4)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(2, 12);
            run_scan(len, $urandom_range(0, 4) == 0);
            sent += len;
        end
    endtask

    // Main stimulus.
    initial
    begin
        int lo;
        int hi;
        int near_mm;
        rst_n = 1'b0;
        samples_if.valid = 1'b0;
        samples_if.sample_range = '0;
        samples_if.sample_nan = 1'b0;
        samples_if.end_of_scan = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        idle_on = 1'b1;
        hold_asked = 0;
        steady_feed = 1'b0;
        win_min = int'(RST_RANGE_MIN);
        win_max = int'(RST_RANGE_MAX);
        win_near = int'(RST_NEAR_LIMIT);
        win_far = int'(RST_FAR_LIMIT);
        win_tol = int'(RST_NEIGHBOR_TOL);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples under the reset settings.
        // Single-sample scans: below the window, above it, too near, in range, NaN.
        send_sample(16'd0, 1'b0, 1'b1);
        send_sample(16'd65535, 1'b0, 1'b1);
        send_sample(16'd300, 1'b0, 1'b1);
        send_sample(16'd1000, 1'b0, 1'b1);
        send_sample(16'd12345, 1'b1, 1'b1);
        // A smooth scan that keeps every sample.
        send_sample(16'd1000, 1'b0, 1'b0);
        send_sample(16'd1150, 1'b0, 1'b0);
        send_sample(16'd1100, 1'b0, 1'b0);
        send_sample(16'd1300, 1'b0, 1'b1);
        // A NaN between two valid samples is never far from them.
        send_sample(16'd2000, 1'b0, 1'b0);
        send_sample(16'hFFFF, 1'b1, 1'b0);
        send_sample(16'd2100, 1'b0, 1'b1);
        // Isolated outlier, beyond the far limit, outside the window on both sides.
        send_sample(16'd1000, 1'b0, 1'b0);
        send_sample(16'd5000, 1'b0, 1'b0);
        send_sample(16'd1000, 1'b0, 1'b0);
        send_sample(16'd7000, 1'b0, 1'b0);
        send_sample(16'd99, 1'b0, 1'b0);
        send_sample(16'd30001, 1'b0, 1'b0);
        send_sample(16'd1000, 1'b0, 1'b1);
        // Exactly on the limits, and a neighbor exactly at the tolerance.
        send_sample(16'd6000, 1'b0, 1'b0);
        send_sample(16'd6001, 1'b0, 1'b0);
        send_sample(16'd500, 1'b0, 1'b1);
        send_sample(16'd3000, 1'b0, 1'b0);
        send_sample(16'd3200, 1'b0, 1'b1);
        run_phase(80);
        drain_results();

        // Widest window, no limits, zero tolerance; the long receiver hold is here.
        load_config(0, 65534, 0, 65535, 0);
        run_phase(20);
        hold_asked <= hold_asked + 1;
        steady_feed = 1'b1;
        run_phase(40);
        steady_feed = 1'b0;
        run_phase(60);
        drain_results();

        // Empty window with crossed limits and the largest tolerance.
        load_config(65534, 65534, 65535, 0, 65535);
        run_phase(60);
        drain_results();

        // Full-scale maximum saturates the replacement; spare indexes are ignored.
        write_reg(REG_SPARE, 32'h1234);
        write_reg(REG_TOP_INDEX, 0);
        load_config(1000, 65535, 0, 65535, 65535);
        run_phase(60);
        drain_results();

        // Random settings; in the first pass the sender also pauses halfway until all results are in.
        for (int p = 0; p < 4; p++)
        begin
            lo = $urandom_range(0, 2000);
            hi = $urandom_range(lo + 500, 65534);
            near_mm = $urandom_range(0, 3000);
            load_config(lo, hi, near_mm, $urandom_range(near_mm, 65535),
                        $urandom_range(0, 1000));
            run_phase(40);
            if (p == 0)
                drain_results();
            run_phase(40);
            drain_results();
        end

        // Closing part at full rate with no idling on either side.
        idle_on <= 1'b0;
        load_config(int'(RST_RANGE_MIN), int'(RST_RANGE_MAX), int'(RST_NEAR_LIMIT),
                    int'(RST_FAR_LIMIT), int'(RST_NEIGHBOR_TOL));
        run_phase(80);
        drain_results();

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/lrip_pkg.sv
hdl/lrip_channels.sv
hdl/lrip_front.sv
hdl/lrip_queue.sv
hdl/lrip_back.sv
hdl/lidar_range_isolated_point_filter_unit.sv
tb/sv/lrip_filter_checker.sv
tb/sv/tb_lidar_range_isolated_point_filter_unit.sv
